// File: rtl/core/bf3_pkg.sv
package bf3_pkg;

  localparam int CH_BITS    = 16;
  localparam int PIX_W      = 3 * CH_BITS;
  localparam int SQ_W       = 2 * CH_BITS;
  localparam int D2_W       = SQ_W + 2;
  localparam int D2_SHIFT   = 14;
  localparam int LUT_SIZE   = 256;
  localparam int LUT_BITS   = 8;
  localparam int W_BITS     = 16;
  localparam int ACC_W      = CH_BITS + W_BITS + 4;
  localparam int WS_W       = 19;
  localparam int POS_W      = 16;
  localparam int ROW_W      = 11;
  localparam int HGT_W      = 12;
  localparam int CFG_W      = 12;
  localparam int MAX_HEIGHT = 2048;
  localparam int CNT_W      = 5;
  localparam int NUM_TAPS   = 9;

  localparam logic [3:0] TAP_CENTRE = 4'd4;
  localparam logic [CNT_W-1:0] TAP_LAST_CNT = CNT_W'(NUM_TAPS + 1);

  localparam logic [W_BITS-1:0] SP_CENTRE = 16'd32768;
  localparam logic [W_BITS-1:0] SP_EDGE   = 16'd19875;
  localparam logic [W_BITS-1:0] SP_CORNER = 16'd12055;

  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [W_BITS-1:0] lut_t [LUT_SIZE];

  function automatic lut_t build_lut();
    lut_t        t;
    logic [95:0] acc;
    acc = 96'd1 << 32;
    for (int n = 0; n < LUT_SIZE; n++) begin
      t[n] = W_BITS'((acc + (96'd1 << 16)) >> 17);
      acc  = (acc * 96'd3979475378 + (96'd1 << 31)) >> 32;
    end
    return t;
  endfunction

  localparam lut_t RANGE_LUT = build_lut();

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LD, S_PICK, S_SETUP, S_TAPS, S_DINIT, S_DIV, S_LOAD, S_OUT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic       ld;
    logic       ctr_load;
    logic       issue;
    logic       div_start;
    logic       div_step;
    logic       out_load;
    logic       yi;
    logic       xi;
    logic [3:0] tap;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic r_nz;
    logic r_last;
    logic c_nz;
    logic c_last;
  } stat_t;

endpackage

// File: rtl/core/bf3_ram.sv
module bf3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/bf3_ctrl.sv
module bf3_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           out_stall,
  input  bf3_pkg::stat_t stat,
  output bf3_pkg::cmd_t  cmd
);
  import bf3_pkg::*;

  state_t           state_r, state_nxt;
  logic [2:0]       ridx_r, ridx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       mask;
  logic [3:0]       higher;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mask[i] = ((i / 2) == 1 ? stat.r_last : stat.r_nz) &&
                ((i % 2) == 1 ? stat.c_last : stat.c_nz);
    end
    higher = (mask >> ridx_r[1:0]) >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ridx_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ridx_r  <= ridx_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ridx_nxt  = ridx_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        ridx_nxt = '0;
        if (in_valid) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_LD;
      S_LD: state_nxt = S_PICK;
      S_PICK: begin
        if (ridx_r[2]) begin
          state_nxt = S_IDLE;
        end else if (mask[ridx_r[1:0]]) begin
          state_nxt = S_SETUP;
        end else begin
          ridx_nxt = ridx_r + 3'd1;
        end
      end
      S_SETUP: begin
        cnt_nxt   = '0;
        state_nxt = S_TAPS;
      end
      S_TAPS: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == TAP_LAST_CNT) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CH_BITS - 1)) state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_stall) begin
          ridx_nxt  = ridx_r + 3'd1;
          state_nxt = S_PICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.yi   = ridx_r[1];
    cmd.xi   = ridx_r[0];
    cmd.tap  = cnt_r[3:0];
    cmd.last = (higher == 4'd0);
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE:  cmd.accept = in_valid;
      S_RD:    cmd.rd = 1'b1;
      S_LD:    cmd.ld = 1'b1;
      S_SETUP: begin
        cmd.ctr_load = 1'b1;
        cmd.tap      = TAP_CENTRE;
      end
      S_TAPS:  cmd.issue = (cnt_r < CNT_W'(NUM_TAPS));
      S_DINIT: cmd.div_start = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_LOAD:  cmd.out_load = 1'b1;
      default: cmd.issue = 1'b0;
    endcase
  end

endmodule

// File: rtl/core/bf3_dpath.sv
module bf3_dpath #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bf3_pkg::cmd_t                cmd,
  output bf3_pkg::stat_t               stat,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_red_in,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_green_in,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_blue_in,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]    cfg_wdata,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bf3_pkg::CH_BITS-1:0]  out_red_out,
  output logic [bf3_pkg::CH_BITS-1:0]  out_green_out,
  output logic [bf3_pkg::CH_BITS-1:0]  out_blue_out,
  output logic                         out_end_of_row,
  output logic                         out_end_of_frame,
  output logic                         out_last_of_item
);
  import bf3_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  function automatic logic [1:0] clip3(input logic signed [POS_W-1:0] k);
    logic [1:0] r;
    if (k < 0) r = 2'd0;
    else if (k > 16'sd2) r = 2'd2;
    else r = k[1:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] clipv(input logic signed [POS_W-1:0] p,
                                                    input logic signed [POS_W-1:0] hi);
    logic signed [POS_W-1:0] v;
    if (p < 0) v = '0;
    else if (p > hi) v = hi;
    else v = p;
    return v;
  endfunction

  function automatic logic [1:0] tap_dy(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_dx(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  logic [CFG_W-1:0]  fw_r, fh_r;
  logic [CW:0]       w_eff;
  logic [HGT_W-1:0]  h_eff;
  logic [CW-1:0]     col_r, cur_c_r, c_norm;
  logic [ROW_W-1:0]  row_r, cur_r_r, r_norm;
  logic [PIX_W-1:0]  px_r;
  logic [PIX_W-1:0]  old_rd, prev_rd;
  logic [PIX_W-1:0]  tap_r [3][3];
  logic [PIX_W-1:0]  ctr_r, smp;
  logic [1:0]        dyi, dxi, rsel, asel;
  logic signed [POS_W-1:0] pos_r, pos_c, hi_r, hi_c, cur_rs, cur_cs;
  logic [SQ_W-1:0]   sq_r [3];
  logic [PIX_W-1:0]  s0_r, s1_r;
  logic [1:0]        sp_r;
  logic              v0_r, v1_r;
  logic [D2_W-1:0]   d2;
  logic [W_BITS-1:0] rw, spw, wt_r;
  logic [2*W_BITS:0] wprod;
  logic [ACC_W-1:0]  sum_r [3];
  logic [WS_W-1:0]   wsum_r;
  logic [WS_W:0]     rem_r [3];
  logic [CH_BITS-1:0] quo_r [3];
  logic [ACC_W:0]    divd [3];
  logic [WS_W:0]     trial [3];
  logic              ov_r, eor_r, eof_r, last_r;
  logic [CH_BITS-1:0] ro_r, go_r, bo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= CFG_W'(640);
      fh_r <= CFG_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        CFG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default:          fw_r <= fw_r;
      endcase
    end
  end

  always_comb begin
    if (fw_r == '0) w_eff = (CW+1)'(1);
    else if (32'(fw_r) > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(fw_r);
    if (fh_r == '0) h_eff = HGT_W'(1);
    else if (32'(fh_r) > 32'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
    else h_eff = HGT_W'(fh_r);
    if ((CW+1)'(col_r) >= w_eff || HGT_W'(row_r) >= h_eff) begin
      c_norm = '0;
      r_norm = '0;
    end else begin
      c_norm = col_r;
      r_norm = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.accept) begin
      if ((CW+1)'(c_norm) + (CW+1)'(1) >= w_eff) begin
        col_r <= '0;
        if (HGT_W'(r_norm) + HGT_W'(1) >= h_eff) row_r <= '0;
        else row_r <= r_norm + ROW_W'(1);
      end else begin
        col_r <= c_norm + CW'(1);
        row_r <= r_norm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_c_r <= c_norm;
      cur_r_r <= r_norm;
      px_r    <= {in_red_in, in_green_in, in_blue_in};
    end
  end

  assign stat.r_nz   = (cur_r_r != '0);
  assign stat.r_last = (HGT_W'(cur_r_r) == h_eff - HGT_W'(1));
  assign stat.c_nz   = (cur_c_r != '0);
  assign stat.c_last = ((CW+1)'(cur_c_r) == w_eff - (CW+1)'(1));

  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk(clk), .we(cmd.ld), .waddr(cur_c_r), .wdata(prev_rd),
    .re(cmd.rd), .raddr(cur_c_r), .rdata(old_rd)
  );

  bf3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_prev (
    .clk(clk), .we(cmd.ld), .waddr(cur_c_r), .wdata(px_r),
    .re(cmd.rd), .raddr(cur_c_r), .rdata(prev_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      for (int k = 0; k < 3; k++) begin
        tap_r[k][2] <= tap_r[k][1];
        tap_r[k][1] <= tap_r[k][0];
      end
      tap_r[0][0] <= old_rd;
      tap_r[1][0] <= prev_rd;
      tap_r[2][0] <= px_r;
    end
  end

  // window position of the current tap, clamped at the frame edges
  always_comb begin
    dyi    = tap_dy(cmd.tap);
    dxi    = tap_dx(cmd.tap);
    cur_rs = POS_W'(cur_r_r);
    cur_cs = POS_W'(cur_c_r);
    hi_r   = POS_W'(h_eff) - 16'sd1;
    hi_c   = POS_W'(w_eff) - 16'sd1;
    pos_r  = cur_rs - 16'sd2 + POS_W'(cmd.yi) + POS_W'(dyi);
    pos_c  = cur_cs - 16'sd2 + POS_W'(cmd.xi) + POS_W'(dxi);
    rsel   = clip3(clipv(pos_r, hi_r) - cur_rs + 16'sd2);
    asel   = clip3(cur_cs - clipv(pos_c, hi_c));
    smp    = tap_r[rsel][asel];
  end

  always_ff @(posedge clk) begin
    if (cmd.ctr_load) ctr_r <= smp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= cmd.issue;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      for (int k = 0; k < 3; k++) begin
        logic [CH_BITS-1:0] a, b, d;
        a = smp[(2-k)*CH_BITS +: CH_BITS];
        b = ctr_r[(2-k)*CH_BITS +: CH_BITS];
        d = (a > b) ? a - b : b - a;
        sq_r[k] <= d * d;
      end
      s0_r <= smp;
      sp_r <= 2'(dxi != 2'd1) + 2'(dyi != 2'd1);
    end
  end

  always_comb begin
    d2 = D2_W'(sq_r[0]) + D2_W'(sq_r[1]) + D2_W'(sq_r[2]);
    if (d2[D2_W-1:D2_SHIFT+LUT_BITS] == '0) rw = RANGE_LUT[d2[D2_SHIFT+LUT_BITS-1:D2_SHIFT]];
    else rw = '0;
    case (sp_r)
      2'd0:    spw = SP_CENTRE;
      2'd1:    spw = SP_EDGE;
      default: spw = SP_CORNER;
    endcase
    wprod = (2*W_BITS+1)'(spw * rw) + (2*W_BITS+1)'(16384);
  end

  always_ff @(posedge clk) begin
    if (v0_r) begin
      wt_r <= wprod[W_BITS+14:15];
      s1_r <= s0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ctr_load) begin
      for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      wsum_r <= '0;
    end else if (v1_r) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= sum_r[k] + ACC_W'(s1_r[(2-k)*CH_BITS +: CH_BITS] * wt_r);
      end
      wsum_r <= wsum_r + WS_W'(wt_r);
    end
  end

  // restoring division, one quotient bit a cycle on all three channels
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      divd[k]  = (ACC_W+1)'(sum_r[k]) + (ACC_W+1)'(wsum_r >> 1);
      trial[k] = {rem_r[k][WS_W-1:0], quo_r[k][CH_BITS-1]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.div_start) begin
        rem_r[k] <= divd[k][CH_BITS +: WS_W+1];
        quo_r[k] <= divd[k][CH_BITS-1:0];
      end else if (cmd.div_step) begin
        if (trial[k] >= (WS_W+1)'(wsum_r)) begin
          rem_r[k] <= trial[k] - (WS_W+1)'(wsum_r);
          quo_r[k] <= {quo_r[k][CH_BITS-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[k];
          quo_r[k] <= {quo_r[k][CH_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.out_load) begin
      ov_r <= 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ro_r   <= quo_r[0];
      go_r   <= quo_r[1];
      bo_r   <= quo_r[2];
      eor_r  <= cmd.xi;
      eof_r  <= cmd.xi & cmd.yi;
      last_r <= cmd.last;
    end
  end

  assign out_valid        = ov_r;
  assign out_red_out      = ro_r;
  assign out_green_out    = go_r;
  assign out_blue_out     = bo_r;
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;
  assign out_last_of_item = last_r;

endmodule

// File: rtl/core/bilateral_filter_3x3_rgb.sv
// 3x3 bilateral filter on a raster-order RGB pixel stream (UQ4.12 channels).
// Input: in_valid/in_stall with one request per pixel. Output: out_valid/
// out_stall, each request one filtered pixel with end of row, end of frame
// and last-of-input flags. An input pixel yields zero to four output pixels;
// output trails input by one row plus one pixel, the last row comes out as
// it arrives. Frame size is set through cfg_we/cfg_index/cfg_wdata while idle.
// One pixel is handled at a time. After acceptance the line buffers are read
// and the window is updated; each output pixel then goes through slot pick,
// set-up, the tap-by-tap weight pipeline, divider load, the bit-serial divider,
// output load and the output state, where the pixel waits until it is taken.
// Every output slot skipped adds a slot pick; an input with no output frees
// the block after the buffer read, the window update and the slot picks.
// in_stall stays high until every output of the current pixel has been taken.
// A stalled output holds its value and the block waits for it.
// Reset clears counters, control and sets the frame to 640x480; line buffers
// need no clearing.
module bilateral_filter_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_red_in,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_green_in,
  input  logic [bf3_pkg::CH_BITS-1:0]  in_blue_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bf3_pkg::CH_BITS-1:0]  out_red_out,
  output logic [bf3_pkg::CH_BITS-1:0]  out_green_out,
  output logic [bf3_pkg::CH_BITS-1:0]  out_blue_out,
  output logic                         out_end_of_row,
  output logic                         out_end_of_frame,
  output logic                         out_last_of_item,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bf3_pkg::CFG_W-1:0]    cfg_wdata
);
  import bf3_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bf3_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  bf3_dpath #(.MAX_WIDTH(MAX_WIDTH)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_end_of_row(out_end_of_row),
    .out_end_of_frame(out_end_of_frame), .out_last_of_item(out_last_of_item)
  );

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid) else $error("output pending while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("no busy after request");

  a_eof_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> (out_end_of_row && out_last_of_item))
    else $error("end of frame flags inconsistent");

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bf3_pkg::*;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        eor;
    logic        eof;
    logic        last;
  } filtered_px_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [15:0]       in_red_in;
  logic [15:0]       in_green_in;
  logic [15:0]       in_blue_in;
  logic              out_valid;
  logic              out_stall;
  logic [15:0]       out_red_out;
  logic [15:0]       out_green_out;
  logic [15:0]       out_blue_out;
  logic              out_end_of_row;
  logic              out_end_of_frame;
  logic              out_last_of_item;
  logic              cfg_we;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  bilateral_filter_3x3_rgb dut (.*);

  // filter state mirror
  logic [47:0]  older_row [2048];
  logic [47:0]  prev_row [2048];
  logic [47:0]  win [3][3];
  logic [15:0]  range_weight [256];
  int           col_pos;
  int           row_pos;
  logic [11:0]  width_reg;
  logic [11:0]  height_reg;
  filtered_px_t expected_pixels [$];
  int           error_count;
  int           hold_off_cycles;
  int           spatial [3] = '{32768, 19875, 12055};
  logic [15:0]  scene_base [3];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic int clip(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic filtered_px_t filter_window(int y, int x, int r, int c, int w, int h);
    filtered_px_t      res;
    logic [47:0]       ctr;
    logic [47:0]       s;
    longint unsigned   sum [3];
    longint unsigned   wsum;
    longint unsigned   d;
    longint unsigned   d2;
    longint unsigned   rw;
    longint unsigned   wt;
    longint unsigned   a;
    longint unsigned   b;
    longint unsigned   q;
    int                rr;
    int                cc;
    ctr = win[clip(y - r + 2, 0, 2)][clip(c - x, 0, 2)];
    sum = '{0, 0, 0};
    wsum = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        rr = clip(y + dy, 0, h - 1);
        cc = clip(x + dx, 0, w - 1);
        s = win[clip(rr - r + 2, 0, 2)][clip(c - cc, 0, 2)];
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          a = s[k*16 +: 16];
          b = ctr[k*16 +: 16];
          d = a > b ? a - b : b - a;
          d2 += d * d;
        end
        q = d2 >> 14;
        rw = q < 256 ? range_weight[q] : 0;
        wt = (longint'(spatial[int'(dx != 0) + int'(dy != 0)]) * rw + 16384) >> 15;
        for (int k = 0; k < 3; k++) sum[k] += longint'(s[k*16 +: 16]) * wt;
        wsum += wt;
      end
    end
    res.red   = wsum != 0 ? 16'((sum[0] + wsum / 2) / wsum) : ctr[15:0];
    res.green = wsum != 0 ? 16'((sum[1] + wsum / 2) / wsum) : ctr[31:16];
    res.blue  = wsum != 0 ? 16'((sum[2] + wsum / 2) / wsum) : ctr[47:32];
    res.eor = x == w - 1;
    res.eof = x == w - 1 && y == h - 1;
    res.last = 1'b0;
    return res;
  endfunction

  function automatic void predict_outputs(logic [15:0] rd, logic [15:0] gr, logic [15:0] bl);
    filtered_px_t res [4];
    logic [47:0]  px;
    int           w;
    int           h;
    int           r;
    int           c;
    int           n;
    w = width_reg == 0 ? 1 : (width_reg > 2048 ? 2048 : width_reg);
    h = height_reg == 0 ? 1 : (height_reg > 2048 ? 2048 : height_reg);
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    px = {bl, gr, rd};
    for (int k = 0; k < 3; k++) begin
      win[k][2] = win[k][1];
      win[k][1] = win[k][0];
    end
    win[0][0] = older_row[c];
    win[1][0] = prev_row[c];
    win[2][0] = px;
    older_row[c] = prev_row[c];
    prev_row[c] = px;
    n = 0;
    for (int y = r - 1; y <= r; y++) begin
      if (y < 0 || (y == r && r != h - 1)) continue;
      for (int x = c - 1; x <= c; x++) begin
        if (x < 0 || (x == c && c != w - 1)) continue;
        res[n] = filter_window(y, x, r, c, w, h);
        n++;
      end
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_pixels.push_back(res[i]);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_pixel(logic [15:0] rd, logic [15:0] gr, logic [15:0] bl, bit gaps = 1);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_red_in = rd;
    in_green_in = gr;
    in_blue_in = bl;
    do @(posedge clk); while (in_stall);
    predict_outputs(rd, gr, bl);
    gap = gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic logic [15:0] near_base(int k);
    int v;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    v = int'(scene_base[k]) + $urandom_range(0, 600) - 300;
    return 16'(clip(v, 0, 65535));
  endfunction

  task automatic push_random(bit gaps = 1);
    push_pixel(near_base(0), near_base(1), near_base(2), gaps);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [11:0] value);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
  endtask

  task automatic set_frame(int w, int h);
    write_reg(CFG_FRAME_WIDTH, 12'(w));
    write_reg(CFG_FRAME_HEIGHT, 12'(h));
    for (int k = 0; k < 3; k++) scene_base[k] = 16'($urandom);
  endtask

  task automatic test_counter_restart();
    // partial row at the reset size, then a narrower frame forces a restart
    for (int i = 0; i < 5; i++) push_random();
    set_frame(3, 2);
    for (int i = 0; i < 6; i++) push_random();
  endtask

  task automatic test_extreme_values();
    set_frame(3, 3);
    push_pixel(16'h0000, 16'h0000, 16'h0000);
    push_pixel(16'hffff, 16'hffff, 16'hffff);
    push_pixel(16'h5555, 16'haaaa, 16'h5555);
    push_pixel(16'haaaa, 16'h5555, 16'haaaa);
    push_pixel(16'h1000, 16'h1000, 16'h1000);
    push_pixel(16'h1010, 16'h0ff0, 16'h1005);
    push_pixel(16'hffff, 16'h0000, 16'hffff);
    push_pixel(16'h1000, 16'h1001, 16'h0fff);
    push_pixel(16'h0000, 16'hffff, 16'h0000);
  endtask

  task automatic test_zero_size();
    set_frame(0, 0);
    for (int i = 0; i < 3; i++) push_random();
  endtask

  task automatic test_max_results();
    set_frame(2, 2);
    for (int i = 0; i < 8; i++) push_random();
  endtask

  task automatic test_oversize();
    set_frame(4095, 1);
    for (int i = 0; i < 24; i++) push_random(0);
    set_frame(1, 4095);
    for (int i = 0; i < 24; i++) push_random(0);
  endtask

  task automatic test_backpressure();
    set_frame(8, 4);
    hold_off_cycles = 400;
    for (int i = 0; i < 32; i++) push_random(0);
    drain();
    for (int i = 0; i < 16; i++) push_random();
  endtask

  task automatic test_random_frames();
    int left;
    int w;
    int h;
    int n;
    left = 200;
    while (left > 0) begin
      w = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(1, 9);
      h = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : $urandom_range(1, 6);
      set_frame(w, h);
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 6) == 0) n = $urandom_range(1, w * h);
      for (int i = 0; i < n; i++) push_random();
      left -= n;
    end
  endtask

  // receiver: random stalls plus forced hold-off
  initial begin
    out_stall = 1'b0;
    hold_off_cycles = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall = 1'b1;
        hold_off_cycles--;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_off_cycles = $urandom_range(15, 60);
        out_stall = 1'b1;
      end else begin
        out_stall = $urandom_range(0, 99) < 25;
      end
    end
  end

  always @(posedge clk) begin
    filtered_px_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected output pixel");
        error_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_red_out !== exp_px.red) begin
          $error("red_out expected %0d got %0d", exp_px.red, out_red_out);
          error_count++;
        end
        if (out_green_out !== exp_px.green) begin
          $error("green_out expected %0d got %0d", exp_px.green, out_green_out);
          error_count++;
        end
        if (out_blue_out !== exp_px.blue) begin
          $error("blue_out expected %0d got %0d", exp_px.blue, out_blue_out);
          error_count++;
        end
        if (out_end_of_row !== exp_px.eor) begin
          $error("end_of_row expected %0d got %0d", exp_px.eor, out_end_of_row);
          error_count++;
        end
        if (out_end_of_frame !== exp_px.eof) begin
          $error("end_of_frame expected %0d got %0d", exp_px.eof, out_end_of_frame);
          error_count++;
        end
        if (out_last_of_item !== exp_px.last) begin
          $error("last_of_item expected %0d got %0d", exp_px.last, out_last_of_item);
          error_count++;
        end
      end
    end
  end

  initial begin
    logic [95:0] acc;
    acc = 96'd1 << 32;
    for (int n = 0; n < 256; n++) begin
      range_weight[n] = 16'((acc + (96'd1 << 16)) >> 17);
      acc = (acc * 96'd3979475378 + (96'd1 << 31)) >> 32;
    end
    foreach (older_row[i]) older_row[i] = '0;
    foreach (prev_row[i]) prev_row[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    width_reg = 12'd640;
    height_reg = 12'd480;
    error_count = 0;
    for (int k = 0; k < 3; k++) scene_base[k] = 16'($urandom);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_counter_restart();
    test_extreme_values();
    test_zero_size();
    test_max_results();
    test_oversize();
    test_backpressure();
    test_random_frames();
    drain();
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
